[hdl/bgrx_to_yuv420_converter_top_macros.svh]
// ----------------------------------------------------------------------------
// bgrx to yuv420 converter assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef BGRX_TO_YUV420_CONVERTER_TOP_MACROS_SVH
`define BGRX_TO_YUV420_CONVERTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication under reset
`define B2Y_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define B2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B2Y_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define B2Y_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hdl/b2y_pkg.sv]
// ----------------------------------------------------------------------------
// b2y package
// shared widths, coefficients, codes and control types of the converter
// ----------------------------------------------------------------------------
package b2y_pkg;

  // field and counter widths
  localparam int DIM_W     = 13;
  localparam int CNT_W     = 12;
  localparam int PIX_W     = 8;
  localparam int LIDX_W    = 24;
  localparam int CIDX_W    = 22;
  localparam int CFG_IDX_W = 4;
  localparam int MAX_DIM   = 4096;

  // fixed-point arithmetic
  localparam int COEF_BITS = 16;
  localparam int PROD_W    = COEF_BITS + PIX_W;
  localparam int DIFF_W    = PROD_W + 1;
  localparam int MUL_W     = DIFF_W + COEF_BITS + 1;
  localparam int HI_W      = MUL_W - 2 * COEF_BITS;

  localparam longint ONE_Q    = longint'(1) << COEF_BITS;
  localparam longint K_R_L    = ((longint'(299) << COEF_BITS) + 500) / 1000;
  localparam longint K_B_L    = ((longint'(114) << COEF_BITS) + 500) / 1000;
  localparam longint K_G_L    = ONE_Q - K_R_L - K_B_L;
  localparam longint K_CB_L   = ((longint'(5642) << COEF_BITS) + 5000) / 10000;
  localparam longint K_CR_L   = ((longint'(713) << COEF_BITS) + 500) / 1000;

  localparam logic [COEF_BITS-1:0] K_R  = COEF_BITS'(K_R_L);
  localparam logic [COEF_BITS-1:0] K_G  = COEF_BITS'(K_G_L);
  localparam logic [COEF_BITS-1:0] K_B  = COEF_BITS'(K_B_L);
  localparam logic [COEF_BITS-1:0] K_CB = COEF_BITS'(K_CB_L);
  localparam logic [COEF_BITS-1:0] K_CR = COEF_BITS'(K_CR_L);

  // reset dimensions
  localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = CFG_IDX_W'(0),
    CFG_FRAME_HEIGHT = CFG_IDX_W'(1)
  } cfg_reg_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_DIFF,
    S_CHROMA,
    S_FINISH
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic step_prod;
    logic step_diff;
    logic step_chroma;
    logic load_out;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // even, at least two, at most the largest frame dimension
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] d;
    d = {raw[DIM_W-1:1], 1'b0};
    if (d < DIM_W'(2)) begin
      d = DIM_W'(2);
    end
    if (d > DIM_W'(MAX_DIM)) begin
      d = DIM_W'(MAX_DIM);
    end
    return d;
  endfunction

endpackage

[hdl/b2y_ctrl.sv]
// ----------------------------------------------------------------------------
// b2y controller
// sequences one pixel through the datapath stages and the output register
// ----------------------------------------------------------------------------
module b2y_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  b2y_pkg::dp_status_t status_i,
  output b2y_pkg::dp_cmd_t    cmd_o,
  output logic                busy_o
);
  import b2y_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PROD;
        end
      end
      S_PROD:   state_d = S_DIFF;
      S_DIFF:   state_d = S_CHROMA;
      S_CHROMA: state_d = S_FINISH;
      S_FINISH: begin
        if (status_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o        = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      S_PROD:   cmd_o.step_prod   = 1'b1;
      S_DIFF:   cmd_o.step_diff   = 1'b1;
      S_CHROMA: cmd_o.step_chroma = 1'b1;
      S_FINISH: cmd_o.load_out    = status_i.out_free;
      default:  busy_o            = 1'b1;
    endcase
  end

endmodule

[hdl/b2y_datapath.sv]
// ----------------------------------------------------------------------------
// b2y datapath
// frame counters, color arithmetic stages, index math and output register
// ----------------------------------------------------------------------------
module b2y_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  b2y_pkg::dp_cmd_t                    cmd_i,
  output b2y_pkg::dp_status_t                 status_o,
  input  logic                                cfg_we_i,
  input  logic [b2y_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [b2y_pkg::DIM_W-1:0]           cfg_data_i,
  input  logic [b2y_pkg::PIX_W-1:0]           blue_i,
  input  logic [b2y_pkg::PIX_W-1:0]           green_i,
  input  logic [b2y_pkg::PIX_W-1:0]           red_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [b2y_pkg::PIX_W-1:0]           luma_value_o,
  output logic [b2y_pkg::LIDX_W-1:0]          luma_index_o,
  output logic                                chroma_valid_o,
  output logic [b2y_pkg::PIX_W-1:0]           blue_diff_value_o,
  output logic [b2y_pkg::PIX_W-1:0]           red_diff_value_o,
  output logic [b2y_pkg::CIDX_W-1:0]          chroma_index_o,
  output logic                                frame_end_o
);
  import b2y_pkg::*;

  // configuration, kept as effective dimensions
  logic [DIM_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  width_q  <= eff_dim(cfg_data_i);
        CFG_FRAME_HEIGHT: height_q <= eff_dim(cfg_data_i);
        default:          width_q  <= width_q;
      endcase
    end
  end

  // position clamp and wrap
  logic [CNT_W-1:0] col_q, row_q, col_d, row_d;
  logic [CNT_W-1:0] col_last, row_last, col_c, row_c;
  logic             last_col, last_row;

  always_comb begin
    col_last = CNT_W'(width_q - DIM_W'(1));
    row_last = CNT_W'(height_q - DIM_W'(1));
    col_c    = (col_q > col_last) ? col_last : col_q;
    row_c    = (row_q > row_last) ? row_last : row_q;
    last_col = (col_c == col_last);
    last_row = (row_c == row_last);
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_c + CNT_W'(1);
    end else begin
      col_d = col_c + CNT_W'(1);
      row_d = row_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.load_in) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // captured pixel and its position
  logic [PIX_W-1:0] blue_q, green_q, red_q;
  logic [CNT_W-1:0] pcol_q, prow_q;
  logic             chroma_q, fend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      blue_q   <= blue_i;
      green_q  <= green_i;
      red_q    <= red_i;
      pcol_q   <= col_c;
      prow_q   <= row_c;
      chroma_q <= ~col_c[0] & ~row_c[0];
      fend_q   <= last_col & last_row;
    end
  end

  // stage one: weighted color products
  logic [PROD_W-1:0] pr_q, pg_q, pb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_prod) begin
      pr_q <= PROD_W'(red_q)   * PROD_W'(K_R);
      pg_q <= PROD_W'(green_q) * PROD_W'(K_G);
      pb_q <= PROD_W'(blue_q)  * PROD_W'(K_B);
    end
  end

  // stage two: luma sum, color differences and plane indexes
  logic [PROD_W-1:0]        ysum_d, ysum_q;
  logic signed [DIFF_W-1:0] dcb_q, dcr_q;
  logic [2*CNT_W:0]         lprod;
  logic [2*CNT_W-2:0]       cprod;
  logic [LIDX_W-1:0]        lidx_q;
  logic [CIDX_W-1:0]        cidx_q;

  assign ysum_d = pr_q + pg_q + pb_q;
  assign lprod  = (2*CNT_W+1)'(prow_q) * (2*CNT_W+1)'(width_q);
  assign cprod  = (2*CNT_W-1)'(prow_q[CNT_W-1:1]) * (2*CNT_W-1)'(width_q[DIM_W-1:1]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_diff) begin
      ysum_q <= ysum_d;
      dcb_q  <= $signed({1'b0, blue_q, COEF_BITS'(0)}) - $signed({1'b0, ysum_d});
      dcr_q  <= $signed({1'b0, red_q, COEF_BITS'(0)}) - $signed({1'b0, ysum_d});
      lidx_q <= LIDX_W'(lprod + (2*CNT_W+1)'(pcol_q));
      cidx_q <= CIDX_W'(cprod + (2*CNT_W-1)'(pcol_q[CNT_W-1:1]));
    end
  end

  // stage three: chroma scaling, integer part kept
  logic signed [MUL_W-1:0] cb_prod, cr_prod;
  logic signed [HI_W-1:0]  cb_hi_q, cr_hi_q;

  assign cb_prod = $signed(dcb_q) * $signed({1'b0, K_CB});
  assign cr_prod = $signed(dcr_q) * $signed({1'b0, K_CR});

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_chroma) begin
      cb_hi_q <= cb_prod[MUL_W-1:2*COEF_BITS];
      cr_hi_q <= cr_prod[MUL_W-1:2*COEF_BITS];
    end
  end

  // offset and clamp to a byte
  logic signed [HI_W+1:0] cb_off, cr_off;
  logic [PIX_W-1:0]       cb_byte, cr_byte;

  always_comb begin
    cb_off = (HI_W+2)'(cb_hi_q) + (HI_W+2)'(128);
    cr_off = (HI_W+2)'(cr_hi_q) + (HI_W+2)'(128);
    if (cb_off < 0) begin
      cb_byte = '0;
    end else if (cb_off > (HI_W+2)'(255)) begin
      cb_byte = '1;
    end else begin
      cb_byte = PIX_W'(cb_off);
    end
    if (cr_off < 0) begin
      cr_byte = '0;
    end else if (cr_off > (HI_W+2)'(255)) begin
      cr_byte = '1;
    end else begin
      cr_byte = PIX_W'(cr_off);
    end
  end

  // output register
  logic out_valid_q;

  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      luma_value_o      <= ysum_q[PROD_W-1:COEF_BITS];
      luma_index_o      <= lidx_q;
      chroma_valid_o    <= chroma_q;
      blue_diff_value_o <= chroma_q ? cb_byte : '0;
      red_diff_value_o  <= chroma_q ? cr_byte : '0;
      chroma_index_o    <= chroma_q ? cidx_q : '0;
      frame_end_o       <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/bgrx_to_yuv420_converter_top.sv]
// ----------------------------------------------------------------------------
// bgrx to yuv420 converter top
// Takes one BGRX pixel per item in raster order and returns its full-range
// BT.601 luma byte with the luma-plane index; on even column and even row the
// same item also carries Cb and Cr bytes (no averaging) with the quarter-plane
// index, and the last pixel of a frame is flagged. An item occupies the block
// from acceptance through three arithmetic stages (color products, luma sum
// with differences and indexes, chroma scaling), run one after another
// through a single set of stage registers, up to the load of the output
// register; a stalled output holds the block in its last step. Frame width and
// height are rounded down to even and limited to 2..4096; write them only while
// the block is idle. The configuration port is always ready.
// ----------------------------------------------------------------------------
`include "bgrx_to_yuv420_converter_top_macros.svh"

module bgrx_to_yuv420_converter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [b2y_pkg::PIX_W-1:0]     blue_i,
  input  logic [b2y_pkg::PIX_W-1:0]     green_i,
  input  logic [b2y_pkg::PIX_W-1:0]     red_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [b2y_pkg::PIX_W-1:0]     luma_value_o,
  output logic [b2y_pkg::LIDX_W-1:0]    luma_index_o,
  output logic                          chroma_valid_o,
  output logic [b2y_pkg::PIX_W-1:0]     blue_diff_value_o,
  output logic [b2y_pkg::PIX_W-1:0]     red_diff_value_o,
  output logic [b2y_pkg::CIDX_W-1:0]    chroma_index_o,
  output logic                          frame_end_o,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [b2y_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [b2y_pkg::DIM_W-1:0]     cfg_data_i
);
  import b2y_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       busy;

  assign in_stall_o  = busy;
  assign cfg_ready_o = 1'b1;

  // controller
  b2y_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // datapath
  b2y_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_valid_i & cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .blue_i            (blue_i),
    .green_i           (green_i),
    .red_i             (red_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .luma_value_o      (luma_value_o),
    .luma_index_o      (luma_index_o),
    .chroma_valid_o    (chroma_valid_o),
    .blue_diff_value_o (blue_diff_value_o),
    .red_diff_value_o  (red_diff_value_o),
    .chroma_index_o    (chroma_index_o),
    .frame_end_o       (frame_end_o)
  );

  // checks
  `B2Y_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "item accepted but block not busy next cycle")
  `B2Y_ASSERT_IMPLY(a_chroma_zero, clk_i, rst_ni, out_valid_o && !chroma_valid_o, blue_diff_value_o == '0 && red_diff_value_o == '0 && chroma_index_o == '0, "chroma fields not zero without chroma")
  `B2Y_ASSERT_IMPLY(a_frame_end_odd, clk_i, rst_ni, out_valid_o && frame_end_o, !chroma_valid_o, "last pixel of frame flagged with chroma")
  `B2Y_ASSERT_IMPLY(a_load_when_free, clk_i, rst_ni, cmd.load_out, status.out_free, "output register loaded while full and stalled")

endmodule
